// ===== design/lwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed level mean package
// Shared widths, payload structs, state encoding and divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package lwm_pkg;

	localparam int DEPTH      = 64;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int LVL_W      = 16;
	localparam int WIN_W      = 7;
	localparam int SUM_W      = LVL_W + ADDR_W;
	localparam int DIV_STEPS  = SUM_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int JUMP_LIMIT = 768;
	localparam int ENTRY_W    = 3 * LVL_W + 1;

	typedef struct packed {
		logic signed [LVL_W-1:0] ild_in;
		logic signed [LVL_W-1:0] left_in;
		logic signed [LVL_W-1:0] right_in;
		logic                    sample_valid;
		logic                    window_valid;
	} in_t;

	typedef struct packed {
		logic signed [LVL_W-1:0] mean_ild;
		logic signed [LVL_W-1:0] mean_left;
		logic signed [LVL_W-1:0] mean_right;
		logic                    mean_ok;
		logic signed [LVL_W-1:0] pick_ild;
		logic signed [LVL_W-1:0] pick_left;
		logic signed [LVL_W-1:0] pick_right;
		logic                    pick_ok;
	} out_t;

	typedef struct packed {
		logic signed [LVL_W-1:0] ild;
		logic signed [LVL_W-1:0] left;
		logic signed [LVL_W-1:0] right;
		logic                    valid;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_st_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== design/lwm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/lwm_sdiv.sv =====
// ----------------------------------------------------------------------------
// Bit-serial signed divider
// Restoring division of a running sum by the window size, one quotient bit
// per cycle, with the quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lwm_sdiv import lwm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SUM_W-1:0] dividend,
	input  wire logic [WIN_W-1:0]        divisor,
	output div_st_t                      st,
	output logic signed [LVL_W-1:0]      quot
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] dvs_q;
	logic [SUM_W-1:0] mag_q;
	logic [WIN_W:0]   part;
	logic [WIN_W:0]   trial;
	logic             ge;
	logic [SUM_W-1:0] res;

	assign part  = {rem_q, mag_q[SUM_W-1]};
	assign ge    = part >= {1'b0, dvs_q};
	assign trial = part - {1'b0, dvs_q};
	assign res   = neg_q ? (~mag_q + SUM_W'(1)) : mag_q;
	assign quot  = res[LVL_W-1:0];
	assign st    = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[WIN_W-1:0] : part[WIN_W-1:0];
			mag_q <= {mag_q[SUM_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ===== design/windowed_level_mean_with_jump_hold.sv =====
// ----------------------------------------------------------------------------
// Windowed level mean with jump hold
// Ring of level samples with running sums, bit-serial means and a jump pick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_data (in_t)
//  out     | output    | out_valid / out_ready  | out_data (out_t)
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_data (window size)
//
// Each request passes through the sum, divide and output states before the
// next is taken; the three bit-serial dividers run side by side. Reset and a
// nonzero window size write clear the ring valid bits, sums and position at
// once; no clearing pass is needed. A result waiting on out_ready does not
// block the next request, which waits only before loading the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_level_mean_with_jump_hold import lwm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_t                  out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [WIN_W-1:0] cfg_data
);

	state_t                  state_q;
	state_t                  state_nx;
	logic [WIN_W-1:0]        win_q;
	logic [ADDR_W-1:0]       wpos_q;
	logic [DEPTH-1:0]        ring_ok_q;
	logic signed [SUM_W-1:0] sum_ild_q;
	logic signed [SUM_W-1:0] sum_left_q;
	logic signed [SUM_W-1:0] sum_right_q;
	in_t                     in_q;
	out_t                    out_q;
	logic                    out_valid_q;

	logic                    in_acc;
	logic                    cfg_acc;
	logic                    do_sum;
	logic                    div_start;
	logic                    out_load;
	logic [ENTRY_W-1:0]      rdata;
	entry_t                  old_e;
	entry_t                  new_e;
	logic signed [SUM_W-1:0] sum_ild_nx;
	logic signed [SUM_W-1:0] sum_left_nx;
	logic signed [SUM_W-1:0] sum_right_nx;
	logic [WIN_W-1:0]        wpos_inc;
	div_st_t                 st_ild;
	div_st_t                 st_left;
	div_st_t                 st_right;
	logic signed [LVL_W-1:0] m_ild;
	logic signed [LVL_W-1:0] m_left;
	logic signed [LVL_W-1:0] m_right;
	logic signed [LVL_W:0]   diff;
	logic                    jump;
	out_t                    res;

	assign in_acc  = in_valid && in_ready;
	assign cfg_acc = cfg_valid && cfg_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nx = ST_SUM;
				end
			end
			ST_SUM: state_nx = ST_DIV;
			ST_DIV: begin
				if (st_ild.done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		do_sum    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cfg_ready = 1'b1;
			end
			ST_SUM: begin
				do_sum    = 1'b1;
				div_start = 1'b1;
			end
			ST_DIV: ;
			ST_OUT: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	lwm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (do_sum),
		.waddr(wpos_q),
		.wdata(new_e),
		.re   (in_acc),
		.raddr(wpos_q),
		.rdata(rdata)
	);

	assign old_e = ring_ok_q[wpos_q] ? entry_t'(rdata) : '0;
	assign new_e = '{ild: in_q.ild_in, left: in_q.left_in, right: in_q.right_in,
		valid: in_q.sample_valid};

	assign sum_ild_nx   = sum_ild_q + SUM_W'(in_q.ild_in) - SUM_W'(old_e.ild);
	assign sum_left_nx  = sum_left_q + SUM_W'(in_q.left_in) - SUM_W'(old_e.left);
	assign sum_right_nx = sum_right_q + SUM_W'(in_q.right_in) - SUM_W'(old_e.right);
	assign wpos_inc     = {1'b0, wpos_q} + WIN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WIN_W'(1);
			wpos_q      <= '0;
			ring_ok_q   <= '0;
			sum_ild_q   <= '0;
			sum_left_q  <= '0;
			sum_right_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_acc && (cfg_data != '0)) begin
				win_q       <= (cfg_data > WIN_W'(DEPTH)) ? WIN_W'(DEPTH) : cfg_data;
				wpos_q      <= '0;
				ring_ok_q   <= '0;
				sum_ild_q   <= '0;
				sum_left_q  <= '0;
				sum_right_q <= '0;
			end else if (do_sum) begin
				ring_ok_q[wpos_q] <= 1'b1;
				sum_ild_q         <= sum_ild_nx;
				sum_left_q        <= sum_left_nx;
				sum_right_q       <= sum_right_nx;
				wpos_q            <= (wpos_inc >= win_q) ? '0 : wpos_inc[ADDR_W-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_data;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	lwm_sdiv u_div_ild (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_ild_nx),
		.divisor (win_q),
		.st      (st_ild),
		.quot    (m_ild)
	);

	lwm_sdiv u_div_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_left_nx),
		.divisor (win_q),
		.st      (st_left),
		.quot    (m_left)
	);

	lwm_sdiv u_div_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_right_nx),
		.divisor (win_q),
		.st      (st_right),
		.quot    (m_right)
	);

	assign diff = (LVL_W+1)'(in_q.ild_in) - (LVL_W+1)'(m_ild);
	assign jump = (diff > (LVL_W+1)'(JUMP_LIMIT)) || (diff < -(LVL_W+1)'(JUMP_LIMIT));

	always_comb begin
		res.mean_ild   = m_ild;
		res.mean_left  = m_left;
		res.mean_right = m_right;
		res.mean_ok    = in_q.window_valid;
		priority if (!in_q.window_valid) begin
			res.pick_ild   = '0;
			res.pick_left  = '0;
			res.pick_right = '0;
			res.pick_ok    = 1'b0;
		end else if (jump) begin
			res.pick_ild   = in_q.ild_in;
			res.pick_left  = in_q.left_in;
			res.pick_right = in_q.right_in;
			res.pick_ok    = in_q.sample_valid;
		end else begin
			res.pick_ild   = m_ild;
			res.pick_left  = m_left;
			res.pick_right = m_right;
			res.pick_ok    = 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_wpos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wpos_q} < win_q)
		else $error("write position outside window");

	a_win_range: assert property (@(posedge clk) disable iff (!arst_n)
		(win_q != '0) && (win_q <= WIN_W'(DEPTH)))
		else $error("window size out of range");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		(st_ild.busy || st_left.busy || st_right.busy) |-> (state_q == ST_DIV))
		else $error("divider busy outside divide state");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(st_ild.done == st_left.done) && (st_ild.done == st_right.done))
		else $error("dividers out of step");

	a_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result loaded outside output state");
`endif

endmodule

`default_nettype wire

// ===== sim/windowed_level_mean_with_jump_hold_test.sv =====
// ----------------------------------------------------------------------------
// Windowed level mean with jump hold testbench
// Sends level samples and window size writes under random backpressure and
// checks every result against a local model of the ring, the means and the
// jump pick.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_level_mean_with_jump_hold_test;
	import lwm_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 5000;
	localparam int CHUNK_ITEMS   = 111;
	localparam int PRINT_LIMIT   = 40;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [WIN_W-1:0] cfg_data  = '0;

	int     ring_ild [DEPTH];
	int     ring_left [DEPTH];
	int     ring_right [DEPTH];
	int     ring_pos;
	int     win_len = 1;
	logic   mean_flag;
	longint sum_ild;
	longint sum_left;
	longint sum_right;

	out_t expected_levels [$];

	int send_idle_pct = 37;
	int recv_idle_pct = 63;
	int level_base;
	int quiet_cycles;
	int n_requests;
	int n_results;
	int n_errors;
	int n_jumps;
	int n_holds;
	int n_unflagged;
	int n_windows;

	windowed_level_mean_with_jump_hold dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void clear_ring_model();
		foreach (ring_ild[i]) begin
			ring_ild[i] = 0;
			ring_left[i] = 0;
			ring_right[i] = 0;
		end
		ring_pos = 0;
		mean_flag = 1'b0;
		sum_ild = 0;
		sum_left = 0;
		sum_right = 0;
	endfunction

	function automatic void apply_window(logic [WIN_W-1:0] size);
		if (size == 0)
			return;
		win_len = (size > DEPTH) ? DEPTH : int'(size);
		clear_ring_model();
	endfunction

	function automatic out_t predict_level(in_t s);
		out_t   r;
		int     slot;
		longint m_ild;
		longint m_left;
		longint m_right;
		longint gap;
		slot = (ring_pos >= win_len) ? 0 : ring_pos;
		sum_ild += longint'(s.ild_in) - ring_ild[slot];
		sum_left += longint'(s.left_in) - ring_left[slot];
		sum_right += longint'(s.right_in) - ring_right[slot];
		ring_ild[slot] = s.ild_in;
		ring_left[slot] = s.left_in;
		ring_right[slot] = s.right_in;
		slot++;
		ring_pos = (slot >= win_len) ? 0 : slot;
		mean_flag = s.window_valid;
		m_ild = sum_ild / win_len;
		m_left = sum_left / win_len;
		m_right = sum_right / win_len;
		r = '0;
		r.mean_ild = LVL_W'(m_ild);
		r.mean_left = LVL_W'(m_left);
		r.mean_right = LVL_W'(m_right);
		r.mean_ok = mean_flag;
		if (!mean_flag) begin
			n_unflagged++;
			return r;
		end
		gap = longint'(s.ild_in) - m_ild;
		if (gap < 0)
			gap = -gap;
		if (gap > JUMP_LIMIT) begin
			n_jumps++;
			r.pick_ild = s.ild_in;
			r.pick_left = s.left_in;
			r.pick_right = s.right_in;
			r.pick_ok = s.sample_valid;
		end else begin
			n_holds++;
			r.pick_ild = r.mean_ild;
			r.pick_left = r.mean_left;
			r.pick_right = r.mean_right;
			r.pick_ok = 1'b1;
		end
		return r;
	endfunction

	function automatic in_t level(int ild, int left, int right, bit sval, bit wval);
		in_t s;
		s.ild_in = LVL_W'(ild);
		s.left_in = LVL_W'(left);
		s.right_in = LVL_W'(right);
		s.sample_valid = sval;
		s.window_valid = wval;
		return s;
	endfunction

	function automatic in_t random_level();
		in_t s;
		int  offset;
		if ($urandom_range(39) == 0)
			level_base = int'($urandom_range(40000)) - 20000;
		s.left_in = LVL_W'($urandom);
		s.right_in = LVL_W'($urandom);
		s.sample_valid = 1'($urandom_range(1));
		s.window_valid = ($urandom_range(4) != 0);
		if ($urandom_range(9) < 3) begin
			s.ild_in = LVL_W'($urandom);
		end else begin
			offset = int'($urandom_range(1600));
			s.ild_in = LVL_W'(level_base + offset - 800);
		end
		return s;
	endfunction

	task automatic report_mismatch(string what, logic [LVL_W-1:0] got,
			logic [LVL_W-1:0] want);
		n_errors++;
		if (n_errors <= PRINT_LIMIT)
			$display("Mismatch on result %0d: %s, got %h, expected %h.",
				n_results, what, got, want);
	endtask

	task automatic send_level(in_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do
			@(posedge clk);
		while (!in_ready);
		expected_levels.push_back(predict_level(s));
		n_requests++;
	endtask

	task automatic drain_levels();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(logic [WIN_W-1:0] size);
		drain_levels();
		cfg_valid <= 1'b1;
		cfg_data <= size;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_window(size);
		n_windows++;
		@(posedge clk);
	endtask

	task automatic test_reset_window();
		send_level(level(32767, -32768, 32767, 1'b1, 1'b1));
		send_level(level(-32768, 32767, -32768, 1'b0, 1'b0));
		send_level(level(0, 0, 0, 1'b1, 1'b1));
	endtask

	task automatic test_full_window();
		write_window(WIN_W'(DEPTH));
		repeat (4) send_level(level(32767, 32767, 32767, 1'b0, 1'b1));
		repeat (2) send_level(level(-32768, -32768, -32768, 1'b1, 1'b1));
		// A zero size is ignored, so the ring keeps its contents.
		write_window('0);
		repeat (2) send_level(level(100, -100, 100, 1'b1, 1'b1));
		write_window('1);
		send_level(level(700, 5, -5, 1'b0, 1'b1));
		send_level(level(800, -5, 5, 1'b0, 1'b1));
		write_window(WIN_W'(DEPTH + 1));
		send_level(level(-1, 1, -1, 1'b1, 1'b1));
	endtask

	task automatic test_jump_threshold();
		write_window(WIN_W'(2));
		send_level(level(1536, 3, -3, 1'b0, 1'b1));
		write_window(WIN_W'(2));
		send_level(level(1538, -3, 3, 1'b0, 1'b1));
		// Negative sums must truncate toward zero.
		write_window(WIN_W'(3));
		send_level(level(-5, -7, -2, 1'b1, 1'b1));
	endtask

	task automatic test_random_traffic();
		logic [WIN_W-1:0] size;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 63 : 0;
			recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 37 : 0;
			for (int chunk = 0; chunk < 6; chunk++) begin
				case (chunk)
					0: begin
						size = WIN_W'(1);
					end
					1: begin
						size = WIN_W'(DEPTH);
					end
					2: begin
						size = WIN_W'($urandom_range(8, 2));
					end
					default: begin
						size = WIN_W'($urandom_range(127));
					end
				endcase
				write_window(size);
				repeat (CHUNK_ITEMS) send_level(random_level());
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			n_results++;
			if (expected_levels.size() == 0) begin
				report_mismatch("result with no request outstanding", out_data.mean_ild, '0);
			end else begin
				want = expected_levels.pop_front();
				if (out_data.mean_ild !== want.mean_ild)
					report_mismatch("mean_ild", out_data.mean_ild, want.mean_ild);
				if (out_data.mean_left !== want.mean_left)
					report_mismatch("mean_left", out_data.mean_left, want.mean_left);
				if (out_data.mean_right !== want.mean_right)
					report_mismatch("mean_right", out_data.mean_right, want.mean_right);
				if (out_data.mean_ok !== want.mean_ok)
					report_mismatch("mean_ok", LVL_W'(out_data.mean_ok),
						LVL_W'(want.mean_ok));
				if (out_data.pick_ild !== want.pick_ild)
					report_mismatch("pick_ild", out_data.pick_ild, want.pick_ild);
				if (out_data.pick_left !== want.pick_left)
					report_mismatch("pick_left", out_data.pick_left, want.pick_left);
				if (out_data.pick_right !== want.pick_right)
					report_mismatch("pick_right", out_data.pick_right, want.pick_right);
				if (out_data.pick_ok !== want.pick_ok)
					report_mismatch("pick_ok", LVL_W'(out_data.pick_ok),
						LVL_W'(want.pick_ok));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding.",
				expected_levels.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		clear_ring_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_full_window();
		test_jump_threshold();
		test_random_traffic();
		drain_levels();
		$display("Sent %0d samples and checked %0d results across %0d window writes.",
			n_requests, n_results, n_windows);
		$display("Picks: %0d jumps, %0d holds, %0d with the flag clear; %0d mismatches.",
			n_jumps, n_holds, n_unflagged, n_errors);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
